>>> sv/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the unsorted-list minimum priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  // operation kinds carried in in_tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // result status codes carried in out_tuser
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // decoupling queue between front and back, depth is a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic               is_delete;
    logic [VALUE_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

>>> sv/mpq_front.sv
// ----------------------------------------------------------------------------
// mpq_front
// Input stage: registers an incoming transaction, decodes its kind and hands
// the operation to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [mpq_pkg::VALUE_W-1:0] in_tdata,   // value
  input  wire logic [0:0]                 in_tuser,   // mode
  input  wire mpq_pkg::q_status_t         q_status,
  output mpq_pkg::op_push_t               push
);

  logic           op_valid_r;
  logic           op_valid_nxt;
  mpq_pkg::op_t   op_r;
  logic           push_go;

  assign push_go   = op_valid_r && !q_status.full;
  assign in_tready = !op_valid_r || push_go;

  always_comb begin
    op_valid_nxt = op_valid_r;
    if (push_go) begin
      op_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      op_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r.is_delete <= (in_tuser[0] == mpq_pkg::MODE_DELETE);
      op_r.value     <= in_tdata;
    end
  end

  assign push.valid = push_go;
  assign push.op    = op_r;

endmodule

`default_nettype wire

>>> sv/mpq_fifo.sv
// ----------------------------------------------------------------------------
// mpq_fifo
// Short operation queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpq_pkg::op_push_t  push,
  input  wire logic               pop,
  output mpq_pkg::op_t            head,
  output mpq_pkg::q_status_t      q_status
);

  mpq_pkg::op_t                  slot_r [mpq_pkg::Q_DEPTH];
  logic [mpq_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mpq_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mpq_pkg::Q_CNT_W-1:0]   fill_r, fill_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign q_status.full  = (fill_r == mpq_pkg::Q_CNT_W'(mpq_pkg::Q_DEPTH));
  assign q_status.empty = (fill_r == '0);
  assign do_push        = push.valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.op;
    end
  end

endmodule

`default_nettype wire

>>> sv/mpq_back.sv
// ----------------------------------------------------------------------------
// mpq_back
// Execution stage: owns the entry memory and count, performs insert and the
// linear delete-min scan, and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_back #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mpq_pkg::op_t                  head,
  input  wire mpq_pkg::q_status_t            q_status,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [39:0]                        out_tdata,  // min_value, count
  output logic [1:0]                         out_tuser   // status
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = mpq_pkg::VALUE_W;

  logic [VW-1:0]            mem [CAPACITY];
  logic [VW-1:0]            rd_data_r;
  logic [IW-1:0]            rd_addr;
  logic                     wr_en;
  logic [IW-1:0]            wr_addr;
  logic [VW-1:0]            wr_data;

  mpq_pkg::back_state_t     state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [IW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic                     first_r, first_nxt;
  logic [VW-1:0]            best_val_r, best_val_nxt;
  logic [IW-1:0]            best_idx_r, best_idx_nxt;
  logic [VW-1:0]            res_min_r, res_min_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [VW-1:0]            out_min_r;
  logic [CW-1:0]            out_count_r;
  logic [1:0]               out_status_r;
  logic                     out_load;
  logic [CW-1:0]            last_idx;
  logic                     take_new;
  logic [CW+6:0]            count_ext;

  assign last_idx = count_r - CW'(1);
  assign take_new = first_r || ($signed(rd_data_r) < $signed(best_val_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    first_nxt      = first_r;
    best_val_nxt   = best_val_r;
    best_idx_nxt   = best_idx_r;
    res_min_nxt    = res_min_r;
    res_status_nxt = res_status_r;
    pop            = 1'b0;
    rd_addr        = rd_idx_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IW-1:0];
    wr_data        = head.value;
    out_load       = 1'b0;
    unique case (state_r)
      mpq_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop            = 1'b1;
          res_min_nxt    = '0;
          res_status_nxt = mpq_pkg::STATUS_OK;
          state_nxt      = mpq_pkg::ST_RESULT;
          if (!head.is_delete) begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = mpq_pkg::STATUS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            res_status_nxt = mpq_pkg::STATUS_EMPTY;
          end else begin
            // start the scan at entry zero
            rd_addr     = '0;
            rd_idx_nxt  = IW'(1);
            cmp_idx_nxt = '0;
            first_nxt   = 1'b1;
            state_nxt   = mpq_pkg::ST_SCAN;
          end
        end
      end
      mpq_pkg::ST_SCAN: begin
        first_nxt = 1'b0;
        if (take_new) begin
          best_val_nxt = rd_data_r;
          best_idx_nxt = cmp_idx_r;
        end
        if (CW'(cmp_idx_r) == last_idx) begin
          // rd_data_r is the last entry: move it into the freed slot
          wr_en       = 1'b1;
          wr_addr     = take_new ? cmp_idx_r : best_idx_r;
          wr_data     = rd_data_r;
          count_nxt   = last_idx;
          res_min_nxt = take_new ? rd_data_r : best_val_r;
          state_nxt   = mpq_pkg::ST_RESULT;
        end else begin
          rd_addr     = rd_idx_r;
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + IW'(1);
        end
      end
      mpq_pkg::ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = mpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_val_r   <= best_val_nxt;
    best_idx_r   <= best_idx_nxt;
    res_min_r    <= res_min_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_min_r    <= res_min_r;
      out_count_r  <= count_r;
      out_status_r <= res_status_r;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign count_ext  = {7'b0, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, count_ext[6:0], out_min_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

>>> sv/min_priority_queue_linear_scan.sv
// ----------------------------------------------------------------------------
// min_priority_queue_linear_scan
// Minimum priority queue of signed 32-bit values kept as an unsorted list.
//
// Input channel in_*: in_tuser[0] is the mode (0 insert, 1 delete-min),
// in_tdata[31:0] the value. Each input transaction gives exactly one result
// on out_*: out_tdata[31:0] removed minimum (zero for insert or error),
// out_tdata[38:32] entry count after the item, out_tuser[1:0] status
// (0 ok, 1 delete on empty queue, 2 insert on full queue dropped).
// A front register and a two-entry queue decouple input from execution.
// Insert and error items pass the front register, the queue, the back's
// IDLE and RESULT states and the output register before out_tvalid rises.
// Delete-min on n entries scans the memory through its single registered
// read port, one entry per cycle. Items execute one at a time. Reset
// empties the queue; memory contents are not cleared and no clearing pass
// runs. A stalled out_tready holds the result in the output register; the
// back finishes its next item and then waits, and input backpressure
// follows once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module min_priority_queue_linear_scan #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value
  input  wire logic [0:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // min_value, count, zero pad
  output logic [1:0]       out_tuser   // status
);

  mpq_pkg::op_push_t  push;
  mpq_pkg::q_status_t q_status;
  mpq_pkg::op_t       head;
  logic               pop;

  mpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push)
  );

  mpq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  mpq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
